/* design/sfr_pkg.sv */
package sfr_pkg;

    // Start-of-frame marker on the serial line.
    localparam logic [7:0] PREAMBLE = 8'hFA;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Receiver phases, one-hot.
    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_BID  = 6'b000010,
        PH_MID  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_CSUM = 6'b100000
    } t_phase;

    // One result beat.
    typedef struct packed {
        logic       kind;
        logic [7:0] message_id;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       checksum_ok;
    } t_result;

endpackage

/* design/sfr_parser.sv */
module sfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_id, n_id;
    logic [7:0] r_len, n_len;
    logic [7:0] r_seen, n_seen;
    logic [7:0] w_sum;
    logic [7:0] w_seen_inc;

    assign w_sum      = r_sum + i_rx_byte;
    assign w_seen_inc = r_seen + 8'd1;

    // Next state and result for the byte offered this cycle.
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_id        = r_id;
        n_len       = r_len;
        n_seen      = r_seen;
        o_res_valid = 1'b0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.message_id   = r_id;
        o_res.payload_byte = 8'd0;
        o_res.byte_index   = 8'd0;
        o_res.frame_length = r_len;
        o_res.checksum_ok  = 1'b0;
        case (r_phase)
            PH_BID: begin
                n_sum   = w_sum;
                n_phase = PH_MID;
            end
            PH_MID: begin
                n_sum   = w_sum;
                n_id    = i_rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_sum   = w_sum;
                n_len   = i_rx_byte;
                n_seen  = 8'd0;
                n_phase = (i_rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                n_sum  = w_sum;
                n_seen = w_seen_inc;
                if (w_seen_inc == r_len) begin
                    n_phase = PH_CSUM;
                end
                o_res_valid        = i_accept;
                o_res.payload_byte = i_rx_byte;
                o_res.byte_index   = r_seen;
            end
            PH_CSUM: begin
                n_sum              = w_sum;
                n_phase            = PH_HUNT;
                o_res_valid        = i_accept;
                o_res.kind         = KIND_END;
                o_res.checksum_ok  = (w_sum == 8'd0);
            end
            default: begin
                // Hunting: drop bytes until the preamble shows up.
                if (i_rx_byte == PREAMBLE) begin
                    n_sum   = 8'd0;
                    n_seen  = 8'd0;
                    n_phase = PH_BID;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Frame state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= 8'd0;
            r_id    <= 8'd0;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_id    <= n_id;
            r_len   <= n_len;
            r_seen  <= n_seen;
        end
    end

endmodule

/* design/sfr_out_buf.sv */
module sfr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfr_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output sfr_pkg::t_result o_data
);
    import sfr_pkg::*;

    logic    r_head_vld;
    logic    r_skid_vld;
    t_result r_head;
    t_result r_skid;
    logic    w_pop;

    assign w_pop   = r_head_vld && !i_stall;
    assign o_valid = r_head_vld;
    assign o_data  = r_head;
    // Upstream is held off only once the skid stage is occupied.
    assign o_full  = r_skid_vld;

    // Valid bits of the output register and the skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_push) begin
                if (r_head_vld && !w_pop) begin
                    r_skid_vld <= 1'b1;
                end
                r_head_vld <= 1'b1;
            end else if (w_pop) begin
                r_head_vld <= r_skid_vld;
                r_skid_vld <= 1'b0;
            end
        end
    end

    // Payload moves: a new beat goes to the head when it frees up, else to the skid.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_head_vld || (w_pop && !r_skid_vld)) begin
                r_head <= i_data;
            end else if (w_pop) begin
                r_head <= r_skid;
                r_skid <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (w_pop) begin
            r_head <= r_skid;
        end
    end

endmodule

/* design/sensor_frame_receiver.sv */
// Result beats are registered in the output register, or the skid stage if that is held.
// One byte per cycle while o_stall is low; the parser steps on every accepted byte.
// A two-deep output register with skid stage keeps input flowing while results wait.
// Reset: synchronous, active low; the parser returns to preamble hunting with cleared
// sum, identifier, length and count, and both output stages are emptied.
module sensor_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_message_id,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_frame_length,
    output logic       o_checksum_ok
);
    import sfr_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;
    logic    w_full;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    // Frame parser.
    sfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register with skid stage.
    sfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_kind         = w_out.kind;
    assign o_message_id   = w_out.message_id;
    assign o_payload_byte = w_out.payload_byte;
    assign o_byte_index   = w_out.byte_index;
    assign o_frame_length = w_out.frame_length;
    assign o_checksum_ok  = w_out.checksum_ok;

endmodule

/* design/sfr_checker.sv */
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_kind,
    input logic [7:0] o_payload_byte,
    input logic [7:0] o_byte_index,
    input logic [7:0] o_frame_length,
    input logic       o_checksum_ok
);
    import sfr_pkg::*;

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat offered right after reset");

    // A stalled beat stays offered with the same payload byte.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte))
        else $error("stalled result beat changed or dropped");

    // Payload beats carry an index inside the declared length and no status.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_PAYLOAD) |->
            (o_byte_index < o_frame_length) && !o_checksum_ok)
        else $error("payload beat index beyond length or status set");

    // End-of-frame beats carry zero payload and zero index.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_END) |->
            (o_payload_byte == 8'd0) && (o_byte_index == 8'd0))
        else $error("end-of-frame beat carries payload data");

endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_payload_byte (o_payload_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_length (o_frame_length),
    .o_checksum_ok  (o_checksum_ok)
);
